[rtl/core/dfu_pkg.sv]
// Shared types, codes and constants of the DFU download request engine.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package dfu_pkg;

  // Sector count of the flash map, default for the top-level parameter
  localparam int DEFAULT_NUM_SECTORS = 8;

  // Configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Register indexes (byte address 4 * index)
  localparam logic [1:0] REG_IFC_SELECT    = 2'd0;
  localparam logic [1:0] REG_TRANSFER_SIZE = 2'd1;
  localparam logic [1:0] REG_PROGRAM_BASE  = 2'd2;
  localparam logic [1:0] REG_MEMORY_LIMIT  = 2'd3;

  // Register reset values
  localparam logic [7:0]  IFC_SELECT_RST    = 8'd0;
  localparam logic [15:0] TRANSFER_SIZE_RST = 16'd1024;
  localparam logic [31:0] PROGRAM_BASE_RST  = 32'h0802_0000;
  localparam logic [31:0] MEMORY_LIMIT_RST  = 32'h0808_0000;

  // DFU request codes
  localparam logic [7:0] CMD_DNLOAD    = 8'd1;
  localparam logic [7:0] CMD_GETSTATUS = 8'd3;
  localparam logic [7:0] CMD_CLRSTATUS = 8'd4;
  localparam logic [7:0] CMD_GETSTATE  = 8'd5;
  localparam logic [7:0] CMD_ABORT     = 8'd6;

  // Request direction
  localparam logic DIR_OUT = 1'b0;
  localparam logic DIR_IN  = 1'b1;

  // Reply codes
  localparam logic [1:0] REPLY_NOTSUPP = 2'd0;
  localparam logic [1:0] REPLY_HANDLED = 2'd1;
  localparam logic [1:0] REPLY_NEXT    = 2'd2;

  // Reply data lengths and the setup length that GETSTATUS must carry
  localparam logic [2:0]  RLEN_GETSTATUS = 3'd6;
  localparam logic [2:0]  RLEN_GETSTATE  = 3'd1;
  localparam logic [15:0] GETSTATUS_LEN  = 16'd6;

  // Flash sector map
  localparam int MAP_SECTORS = 8;
  localparam logic [31:0] SECTOR_START [MAP_SECTORS] = '{
    32'h0800_0000, 32'h0800_4000, 32'h0800_8000, 32'h0800_C000,
    32'h0801_0000, 32'h0802_0000, 32'h0804_0000, 32'h0806_0000
  };
  localparam logic [31:0] FLASH_LAST = 32'h0807_FFFF;

  // DFU device states
  typedef enum logic [3:0] {
    ST_IDLE          = 4'd2,
    ST_DNLOAD_SYNC   = 4'd3,
    ST_DNLOAD_IDLE   = 4'd5,
    ST_MANIFEST_SYNC = 4'd6,
    ST_ERROR         = 4'd10
  } dfu_state_t;

  // DFU status codes
  typedef enum logic [3:0] {
    STAT_OK          = 4'd0,
    STAT_ERR_ADDRESS = 4'd8,
    STAT_ERR_UNKNOWN = 4'd14
  } dfu_status_t;

  // Request beat
  typedef struct packed {
    logic        direction_in;
    logic [7:0]  command;
    logic [15:0] interface_index;
    logic [15:0] request_length;
  } dfu_req_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  reply_code;
    logic        erase_valid;
    logic [2:0]  erase_sector;
    logic        program_valid;
    logic [31:0] program_address;
    logic [15:0] program_length;
    logic [3:0]  status_byte;
    logic [3:0]  state_byte;
    logic [2:0]  reply_length;
  } dfu_rsp_t;

  // Configuration register values
  typedef struct packed {
    logic [7:0]  ifc_select;
    logic [15:0] transfer_size;
    logic [31:0] program_base;
    logic [31:0] memory_limit;
  } dfu_cfg_t;

  // Engine context, apart from the erased-sector map
  typedef struct packed {
    dfu_state_t  state;
    dfu_status_t status;
    logic [31:0] write_address;
  } dfu_ctx_t;

  // Map a flash address to its sector; addresses off the map fall to sector 0
  function automatic logic [2:0] sector_of(input logic [31:0] addr);
    logic [2:0] found;
    found = 3'd0;
    if (addr >= SECTOR_START[0] && addr <= FLASH_LAST) begin
      for (int s = 0; s < MAP_SECTORS; s++) begin
        if (addr >= SECTOR_START[s]) begin
          found = 3'(s);
        end
      end
    end
    return found;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dfu_cfg_regs.sv]
// Configuration register file of the DFU engine behind an APB-style port.
// Depends on dfu_pkg for register indexes, reset values and dfu_cfg_t.
`default_nettype none

module dfu_cfg_regs
  import dfu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output dfu_cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;

  // Write registers in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ifc_select    <= IFC_SELECT_RST;
      cfg.transfer_size <= TRANSFER_SIZE_RST;
      cfg.program_base  <= PROGRAM_BASE_RST;
      cfg.memory_limit  <= MEMORY_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_index)
        REG_IFC_SELECT:    cfg.ifc_select    <= pwdata[7:0];
        REG_TRANSFER_SIZE: cfg.transfer_size <= pwdata[15:0];
        REG_PROGRAM_BASE:  cfg.program_base  <= pwdata;
        REG_MEMORY_LIMIT:  cfg.memory_limit  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_index)
      REG_IFC_SELECT:    prdata = {24'd0, cfg.ifc_select};
      REG_TRANSFER_SIZE: prdata = {16'd0, cfg.transfer_size};
      REG_PROGRAM_BASE:  prdata = cfg.program_base;
      REG_MEMORY_LIMIT:  prdata = cfg.memory_limit;
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/dfu_engine.sv]
// Request decode, DFU state machine update and result formation for one beat.
// Purely combinational; depends on dfu_pkg for codes, types and sector_of.
`default_nettype none

module dfu_engine
  import dfu_pkg::*;
#(
  parameter int NUM_SECTORS = DEFAULT_NUM_SECTORS
) (
  input  wire dfu_req_t               req,
  input  wire dfu_cfg_t               cfg,
  input  wire dfu_ctx_t               ctx,
  input  wire logic [NUM_SECTORS-1:0] erased_map,
  output dfu_ctx_t               ctx_next,
  output logic [NUM_SECTORS-1:0] erased_map_next,
  output dfu_rsp_t               rsp
);

  logic                   ifc_match;
  logic                   is_dnload;
  logic                   is_getstatus;
  logic                   is_clrstatus;
  logic                   is_getstate;
  logic                   is_abort;
  logic                   len_zero;
  logic                   len_big;
  logic                   len_status;
  logic [32:0]            end_address;
  logic                   addr_oob;
  logic                   dn_ok;
  logic [2:0]             sector_raw;
  logic [2:0]             sector;
  logic [NUM_SECTORS-1:0] sector_mask;
  logic                   sector_erased;
  logic                   do_reset;

  // Decode the request and evaluate the download checks
  always_comb begin
    ifc_match    = (req.interface_index[7:0] == cfg.ifc_select);
    is_dnload    = ifc_match && (req.direction_in == DIR_OUT) && (req.command == CMD_DNLOAD);
    is_getstatus = ifc_match && (req.direction_in == DIR_IN) &&
                   (req.command == CMD_GETSTATUS);
    is_clrstatus = ifc_match && (req.direction_in == DIR_OUT) &&
                   (req.command == CMD_CLRSTATUS);
    is_getstate  = ifc_match && (req.direction_in == DIR_IN) && (req.command == CMD_GETSTATE);
    is_abort     = ifc_match && (req.direction_in == DIR_OUT) && (req.command == CMD_ABORT);

    len_zero    = (req.request_length == 16'd0);
    len_big     = (req.request_length > cfg.transfer_size);
    len_status  = (req.request_length == GETSTATUS_LEN);
    end_address = {1'b0, ctx.write_address} + {17'd0, req.request_length};
    addr_oob    = (end_address > {1'b0, cfg.memory_limit});
    dn_ok       = is_dnload && !len_zero && !len_big && !addr_oob;

    sector_raw = sector_of(ctx.write_address);
    sector     = (int'(sector_raw) >= NUM_SECTORS) ? 3'd0 : sector_raw;

    sector_mask   = '0;
    sector_erased = 1'b0;
    for (int i = 0; i < NUM_SECTORS; i++) begin
      if (int'(sector) == i) begin
        sector_mask[i] = 1'b1;
        sector_erased  = erased_map[i];
      end
    end

    do_reset = is_abort ||
               (is_clrstatus && ctx.state == ST_ERROR) ||
               (is_getstatus && len_status && ctx.state == ST_MANIFEST_SYNC);
  end

  // Next state
  always_comb begin
    ctx_next        = ctx;
    erased_map_next = erased_map;
    if (do_reset) begin
      ctx_next.state         = ST_IDLE;
      ctx_next.status        = STAT_OK;
      ctx_next.write_address = cfg.program_base;
      erased_map_next        = '0;
    end else if (is_dnload) begin
      if (len_zero) begin
        ctx_next.status = STAT_OK;
        ctx_next.state  = ST_MANIFEST_SYNC;
      end else if (len_big) begin
        ctx_next.state  = ST_ERROR;
        ctx_next.status = STAT_ERR_UNKNOWN;
      end else if (addr_oob) begin
        ctx_next.state  = ST_ERROR;
        ctx_next.status = STAT_ERR_ADDRESS;
      end else begin
        ctx_next.status        = STAT_OK;
        ctx_next.state         = ST_DNLOAD_SYNC;
        ctx_next.write_address = ctx.write_address + 32'(req.request_length);
        erased_map_next        = erased_map | sector_mask;
      end
    end else if (is_getstatus && len_status && ctx.state == ST_DNLOAD_SYNC) begin
      ctx_next.state = ST_DNLOAD_IDLE;
    end
  end

  // Result beat
  always_comb begin
    rsp = '0;
    if (!ifc_match) begin
      rsp.reply_code = REPLY_NOTSUPP;
    end else if (is_dnload) begin
      rsp.reply_code = len_big ? REPLY_NOTSUPP : REPLY_HANDLED;
      if (dn_ok) begin
        rsp.erase_valid     = !sector_erased;
        rsp.erase_sector    = sector_erased ? 3'd0 : sector;
        rsp.program_valid   = 1'b1;
        rsp.program_address = ctx.write_address;
        rsp.program_length  = req.request_length;
      end
    end else if (is_getstatus) begin
      if (len_status) begin
        rsp.reply_code   = REPLY_HANDLED;
        rsp.status_byte  = 4'(ctx.status);
        rsp.state_byte   = 4'(ctx_next.state);
        rsp.reply_length = RLEN_GETSTATUS;
      end else begin
        rsp.reply_code = REPLY_NOTSUPP;
      end
    end else if (is_clrstatus || is_abort) begin
      rsp.reply_code = REPLY_HANDLED;
    end else if (is_getstate) begin
      rsp.reply_code   = REPLY_HANDLED;
      rsp.state_byte   = 4'(ctx.state);
      rsp.reply_length = RLEN_GETSTATE;
    end else begin
      rsp.reply_code = REPLY_NEXT;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dfu_download_request_fsm.sv]
// DFU 1.1 download request engine: input register, engine state, result register.
// Depends on dfu_pkg, dfu_cfg_regs and dfu_engine.
//
// Usage:
//   Each beat on req carries one decoded USB class request (direction,
//   request code, interface index, setup length). The block answers it with
//   exactly one beat on rsp: reply code, optional sector erase, optional
//   program command, and the status/state bytes for GETSTATUS and GETSTATE.
//   Both channels use valid/ready; pready is always high. The user must write
//   configuration (interface number, transfer size, program base, memory limit)
//   through the APB-style port with no request in flight; it is not enforced.
// Timing:
//   A request is taken into the input register, evaluated by the engine and
//   its result is loaded into the result register when the beat leaves the
//   input register, at the same edge as the engine state is updated. While rsp
//   is not stalled, throughput is one request per cycle.
// Reset and stalls:
//   rst returns the state to dfuIDLE, status OK, write address to the reset
//   program base, and clears the erased-sector map and both valid flags.
//   While rsp is stalled the input register still takes one more request;
//   after that req_ready drops until the result beat is taken.
`default_nettype none

module dfu_download_request_fsm
  import dfu_pkg::*;
#(
  parameter int NUM_SECTORS = DEFAULT_NUM_SECTORS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire dfu_req_t              req,
  // result channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output dfu_rsp_t                   rsp,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  dfu_cfg_t               cfg;
  logic                   stage_valid;
  dfu_req_t               stage_req;
  logic                   advance;
  dfu_ctx_t               ctx;
  dfu_ctx_t               ctx_next;
  logic [NUM_SECTORS-1:0] erased_map;
  logic [NUM_SECTORS-1:0] erased_map_next;
  dfu_rsp_t               rsp_next;

  dfu_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dfu_engine #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_engine (
    .req             (stage_req),
    .cfg             (cfg),
    .ctx             (ctx),
    .erased_map      (erased_map),
    .ctx_next        (ctx_next),
    .erased_map_next (erased_map_next),
    .rsp             (rsp_next)
  );

  // Move the staged beat on when the result register is free or draining
  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_req <= req;
    end
  end

  // Engine state, updated as the beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state         <= ST_IDLE;
      ctx.status        <= STAT_OK;
      ctx.write_address <= PROGRAM_BASE_RST;
      erased_map        <= '0;
    end else if (advance) begin
      ctx        <= ctx_next;
      erased_map <= erased_map_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[verif/dfu_download_request_fsm_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the DFU download request engine: drives request beats and APB
// writes, predicts each result beat and compares it field by field. Depends on dfu_pkg and dfu_download_request_fsm.

module tb;
  import dfu_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int MAX_WAIT    = 12;
  localparam int TIMEOUT_NS  = 1_000_000;

  // Request codes outside the served subset
  localparam logic [7:0] CMD_DETACH = 8'd0;
  localparam logic [7:0] CMD_UPLOAD = 8'd2;
  localparam logic [7:0] CMD_UNUSED = 8'hFF;

  // Flash sector start addresses and the last flash byte
  localparam logic [31:0] FLASH_BASE_TBL [8] = '{
    32'h0800_0000, 32'h0800_4000, 32'h0800_8000, 32'h0800_C000,
    32'h0801_0000, 32'h0802_0000, 32'h0804_0000, 32'h0806_0000
  };
  localparam logic [31:0] FLASH_TOP = 32'h0807_FFFF;

  // Shadow of the engine: predicts every result beat and holds them in order
  class dfu_scoreboard;
    dfu_cfg_t    regs;
    dfu_state_t  state;
    dfu_status_t status;
    logic [31:0] wr_addr;
    logic [7:0]  erased;
    dfu_rsp_t    expected_rsp[$];
    int          errors;
    int          beats;

    function new();
      regs.ifc_select    = IFC_SELECT_RST;
      regs.transfer_size = TRANSFER_SIZE_RST;
      regs.program_base  = PROGRAM_BASE_RST;
      regs.memory_limit  = MEMORY_LIMIT_RST;
      errors = 0;
      beats  = 0;
      restart();
    endfunction

    // Return the engine to idle; program base is picked up only here
    function void restart();
      state   = ST_IDLE;
      status  = STAT_OK;
      wr_addr = regs.program_base;
      erased  = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_IFC_SELECT:    regs.ifc_select    = v[7:0];
        REG_TRANSFER_SIZE: regs.transfer_size = v[15:0];
        REG_PROGRAM_BASE:  regs.program_base  = v;
        REG_MEMORY_LIMIT:  regs.memory_limit  = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_IFC_SELECT:    return {24'd0, regs.ifc_select};
        REG_TRANSFER_SIZE: return {16'd0, regs.transfer_size};
        REG_PROGRAM_BASE:  return regs.program_base;
        default:           return regs.memory_limit;
      endcase
    endfunction

    // Addresses off the flash map fall to sector 0
    function logic [2:0] flash_sector(logic [31:0] a);
      if (a < FLASH_BASE_TBL[0] || a > FLASH_TOP) return 3'd0;
      for (int s = 7; s > 0; s--) begin
        if (a >= FLASH_BASE_TBL[s]) return 3'(s);
      end
      return 3'd0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Advance the shadow state by one accepted request and queue its result
    function void note_request(dfu_req_t r);
      dfu_rsp_t   e;
      logic [2:0] sec;
      e = '0;
      e.reply_code = REPLY_NEXT;
      if (r.interface_index[7:0] != regs.ifc_select) begin
        e.reply_code = REPLY_NOTSUPP;
      end else if (r.direction_in == DIR_OUT && r.command == CMD_DNLOAD) begin
        if (r.request_length == 16'd0) begin
          status = STAT_OK;
          state  = ST_MANIFEST_SYNC;
          e.reply_code = REPLY_HANDLED;
        end else if (r.request_length > regs.transfer_size) begin
          state  = ST_ERROR;
          status = STAT_ERR_UNKNOWN;
          e.reply_code = REPLY_NOTSUPP;
        end else if ({1'b0, wr_addr} + {17'd0, r.request_length} > {1'b0, regs.memory_limit}) begin
          state  = ST_ERROR;
          status = STAT_ERR_ADDRESS;
          e.reply_code = REPLY_HANDLED;
        end else begin
          sec    = flash_sector(wr_addr);
          status = STAT_OK;
          state  = ST_DNLOAD_SYNC;
          // erase a sector only the first time it is written
          if (!erased[sec]) begin
            e.erase_valid  = 1'b1;
            e.erase_sector = sec;
            erased[sec]    = 1'b1;
          end
          e.program_valid   = 1'b1;
          e.program_address = wr_addr;
          e.program_length  = r.request_length;
          wr_addr = wr_addr + 32'(r.request_length);
          e.reply_code = REPLY_HANDLED;
        end
      end else if (r.direction_in == DIR_IN && r.command == CMD_GETSTATUS) begin
        if (r.request_length != GETSTATUS_LEN) begin
          e.reply_code = REPLY_NOTSUPP;
        end else begin
          // status is reported as it was, state as it becomes
          e.status_byte = status;
          if (state == ST_DNLOAD_SYNC) begin
            state = ST_DNLOAD_IDLE;
          end else if (state == ST_MANIFEST_SYNC) begin
            restart();
          end
          e.state_byte   = state;
          e.reply_length = RLEN_GETSTATUS;
          e.reply_code   = REPLY_HANDLED;
        end
      end else if (r.direction_in == DIR_OUT && r.command == CMD_CLRSTATUS) begin
        if (state == ST_ERROR) restart();
        e.reply_code = REPLY_HANDLED;
      end else if (r.direction_in == DIR_IN && r.command == CMD_GETSTATE) begin
        e.state_byte   = state;
        e.reply_length = RLEN_GETSTATE;
        e.reply_code   = REPLY_HANDLED;
      end else if (r.direction_in == DIR_OUT && r.command == CMD_ABORT) begin
        restart();
        e.reply_code = REPLY_HANDLED;
      end
      expected_rsp.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task match_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h", beats, field, got, want));
      end
    endtask

    // Compare one result beat with the oldest prediction
    task check_result(dfu_rsp_t got);
      dfu_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("beat %0d arrived with no request outstanding", beats));
      end else begin
        want = expected_rsp.pop_front();
        match_field("reply_code", got.reply_code, want.reply_code);
        match_field("erase_valid", got.erase_valid, want.erase_valid);
        match_field("erase_sector", got.erase_sector, want.erase_sector);
        match_field("program_valid", got.program_valid, want.program_valid);
        match_field("program_address", got.program_address, want.program_address);
        match_field("program_length", got.program_length, want.program_length);
        match_field("status_byte", got.status_byte, want.status_byte);
        match_field("state_byte", got.state_byte, want.state_byte);
        match_field("reply_length", got.reply_length, want.reply_length);
      end
      beats++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  dfu_req_t              req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  dfu_rsp_t              rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  dfu_scoreboard sb;
  int            sent_count;
  bit            req_steady;
  bit            rsp_steady;

  dfu_download_request_fsm u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  function automatic dfu_req_t make_req(logic dir, logic [7:0] cmd, logic [15:0] ifc,
                                        logic [15:0] len);
    dfu_req_t r;
    r.direction_in    = dir;
    r.command         = cmd;
    r.interface_index = ifc;
    r.request_length  = len;
    return r;
  endfunction

  // Matching interface in the low byte, random upper byte
  function automatic logic [15:0] own_interface();
    return {8'($urandom), sb.regs.ifc_select};
  endfunction

  // Present one request beat, after a random gap unless req_steady is set, and hold it until taken
  task automatic send_request(dfu_req_t r);
    int gap;
    gap = req_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_cmd(logic dir, logic [7:0] cmd, logic [15:0] len);
    send_request(make_req(dir, cmd, own_interface(), len));
  endtask

  // Hold off new requests until every predicted beat has come back
  task automatic drain();
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    paddr   = {idx, 2'b00};
    pwdata  = value;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read a register back and compare it with the written value
  task automatic apb_check(logic [1:0] idx, logic [31:0] mask);
    logic [31:0] got;
    paddr   = {idx, 2'b00};
    pwrite  = 1'b0;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if ((got & mask) !== (sb.reg_value(idx) & mask)) begin
      sb.report($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, got,
                          sb.reg_value(idx)));
    end
  endtask

  task automatic configure(logic [7:0] ifc, logic [15:0] ts, logic [31:0] base,
                           logic [31:0] lim);
    drain();
    apb_write(REG_IFC_SELECT, {24'd0, ifc});
    apb_write(REG_TRANSFER_SIZE, {16'd0, ts});
    apb_write(REG_PROGRAM_BASE, base);
    apb_write(REG_MEMORY_LIMIT, lim);
    apb_check(REG_IFC_SELECT, 32'h0000_00FF);
    apb_check(REG_TRANSFER_SIZE, 32'h0000_FFFF);
    apb_check(REG_PROGRAM_BASE, 32'hFFFF_FFFF);
    apb_check(REG_MEMORY_LIMIT, 32'hFFFF_FFFF);
  endtask

  // Mostly small blocks, some full-size, some oversized, a few zero-length
  function automatic logic [15:0] pick_length();
    int ts;
    int r;
    ts = sb.regs.transfer_size;
    r  = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, ts < 512 ? ts : 512));
    if (r < 72) return 16'(ts);
    if (r < 84) return 16'($urandom_range(1, ts));
    if (r < 92) return (ts >= 65535) ? 16'hFFFF : 16'($urandom_range(ts + 1, 65535));
    return 16'd0;
  endfunction

  function automatic logic [31:0] pick_base();
    logic [31:0] start;
    start = FLASH_BASE_TBL[$urandom_range(0, 7)];
    case ($urandom_range(0, 7))
      0, 1:    return start;
      2, 3:    return start - 32'($urandom_range(1, 3000));
      4:       return 32'($urandom_range(32'h0800_0000, 32'h0807_FFFF));
      5:       return 32'h0000_0000;
      6:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'hFFFF_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit(logic [31:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return MEMORY_LIMIT_RST;
      4, 5:       return 32'hFFFF_FFFF;
      6, 7:       return base + 32'($urandom_range(0, 300000));
      8:          return 32'h0000_0000;
      default:    return 32'($urandom);
    endcase
  endfunction

  // One host download: blocks with status polls, then a random ending
  task automatic run_session();
    int nblk;
    nblk = $urandom_range(1, 10);
    repeat (nblk) begin
      send_cmd(DIR_OUT, CMD_DNLOAD, pick_length());
      repeat ($urandom_range(1, 2)) send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
      if ($urandom_range(0, 7) == 0) send_cmd(DIR_IN, CMD_GETSTATE, RLEN_GETSTATE);
    end
    case ($urandom_range(0, 3))
      0: begin
        send_cmd(DIR_OUT, CMD_DNLOAD, 16'd0);
        send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
      end
      1: send_cmd(DIR_OUT, CMD_ABORT, 16'd0);
      2: begin
        send_cmd(DIR_OUT, CMD_CLRSTATUS, 16'd0);
        send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
      end
      default: ;
    endcase
  endtask

  // Stray requests: any direction, code, interface and length
  task automatic send_noise();
    logic        dir;
    logic [7:0]  cmd;
    logic [15:0] ifc;
    logic [15:0] len;
    dir = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0, 1:    cmd = CMD_DNLOAD;
      2, 3:    cmd = CMD_GETSTATUS;
      4:       cmd = CMD_CLRSTATUS;
      5:       cmd = CMD_GETSTATE;
      6:       cmd = CMD_ABORT;
      7:       cmd = CMD_UPLOAD;
      8:       cmd = CMD_DETACH;
      default: cmd = 8'($urandom);
    endcase
    ifc = ($urandom_range(0, 9) < 7) ? own_interface() : 16'($urandom);
    case ($urandom_range(0, 4))
      0, 1:    len = GETSTATUS_LEN;
      2:       len = 16'd0;
      default: len = 16'($urandom);
    endcase
    send_request(make_req(dir, cmd, ifc, len));
  endtask

  task automatic run_phase();
    logic [7:0]  ifc;
    logic [15:0] ts;
    logic [31:0] base;
    int          target;
    case ($urandom_range(0, 2))
      0:       ifc = 8'h00;
      1:       ifc = 8'hFF;
      default: ifc = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       ts = 16'd1;
      1:       ts = 16'hFFFF;
      2:       ts = TRANSFER_SIZE_RST;
      default: ts = 16'($urandom_range(1, 65535));
    endcase
    base = pick_base();
    configure(ifc, ts, base, pick_limit(base));
    req_steady = ($urandom_range(0, 3) == 0);
    rsp_steady = ($urandom_range(0, 3) == 0);
    // abort usually, so the new base takes effect
    if ($urandom_range(0, 4) != 0) send_cmd(DIR_OUT, CMD_ABORT, 16'd0);
    target = sent_count + $urandom_range(40, 120);
    while (sent_count < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        run_session();
      end
    end
  endtask

  // Result side: random stall unless rsp_steady is set, then take one beat and check it
  initial begin
    int hold;
    rsp_ready = 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    forever begin
      hold = rsp_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold != 0) begin
        rsp_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      sb.check_result(rsp);
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin
    sb         = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    sent_count = 0;
    req_steady = 1'b0;
    rsp_steady = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: status/state reports, errors, pass-through requests
    send_cmd(DIR_IN, CMD_GETSTATE, 16'd1);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN + 16'd1);
    send_cmd(DIR_OUT, CMD_DNLOAD, TRANSFER_SIZE_RST);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
    send_cmd(DIR_OUT, CMD_DNLOAD, TRANSFER_SIZE_RST + 16'd1);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
    send_cmd(DIR_OUT, CMD_CLRSTATUS, 16'd0);
    send_request(make_req(DIR_OUT, CMD_ABORT, 16'h00FF, 16'd0));
    send_cmd(DIR_IN, CMD_DNLOAD, 16'd64);
    send_cmd(DIR_OUT, CMD_UNUSED, 16'hFFFF);
    send_cmd(DIR_IN, CMD_UPLOAD, 16'd64);
    send_cmd(DIR_OUT, CMD_DNLOAD, 16'd0);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
    send_cmd(DIR_OUT, CMD_ABORT, 16'd0);

    // top of the address space: full block fits, next byte overflows the limit
    configure(8'hFF, 16'hFFFF, 32'hFFFF_0000, 32'hFFFF_FFFF);
    send_cmd(DIR_OUT, CMD_ABORT, 16'd0);
    send_cmd(DIR_OUT, CMD_DNLOAD, 16'hFFFF);
    send_cmd(DIR_OUT, CMD_DNLOAD, 16'd1);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);
    send_cmd(DIR_OUT, CMD_CLRSTATUS, 16'd0);

    // sector boundary crossing with one-byte blocks
    configure(8'h00, 16'd1, 32'h0800_3FFF, 32'h0800_4001);
    send_cmd(DIR_OUT, CMD_ABORT, 16'd0);
    send_cmd(DIR_OUT, CMD_DNLOAD, 16'd1);
    send_cmd(DIR_OUT, CMD_DNLOAD, 16'd1);
    send_cmd(DIR_OUT, CMD_DNLOAD, 16'd1);
    send_cmd(DIR_IN, CMD_GETSTATUS, GETSTATUS_LEN);

    // random phases, each under a fresh register setting
    while (sent_count < ITEM_TARGET) run_phase();

    // wait out the remaining beats, then a few more cycles
    req_valid = 1'b0;
    for (int i = 0; i < 2000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d result beats never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/dfu_pkg.sv
rtl/core/dfu_cfg_regs.sv
rtl/core/dfu_engine.sv
rtl/core/dfu_download_request_fsm.sv
verif/dfu_download_request_fsm_tb.sv
